### rtl/ssr_pkg.sv
// Shared constants, types and the sigmoid weight table of the step-rate ramp unit.
package ssr_pkg;

  localparam int RAMP_STEPS       = 400;
  localparam int WEIGHT_FRAC_BITS = 16;

  localparam int FREQ_W   = 17;
  localparam int CLOCK_W  = 22;
  localparam int ALOAD_W  = 16;
  localparam int INDEX_W  = 9;
  localparam int PULSE_W  = 21;
  localparam int CFG_IDX_W = 1;

  localparam int CNT_W     = $clog2(RAMP_STEPS + 1);
  localparam int W_ENTRIES = RAMP_STEPS / 2 + 1;
  localparam int M_W       = $clog2(W_ENTRIES);

  // Duty window of the analog pulse: (f - 1000) / 9000 of the analog load
  localparam int DUTY_W = 14;
  localparam logic [FREQ_W-1:0] F_LOW    = FREQ_W'(1000);
  localparam logic [FREQ_W-1:0] F_HIGH   = FREQ_W'(10000);
  localparam logic [63:0]       DUTY_DEN = 64'd9000;

  // Reciprocal of the duty span, exact for every dividend of SCALE_W bits
  localparam int SCALE_W    = ALOAD_W + DUTY_W;
  localparam int DUTY_SHIFT = 44;
  localparam int RECIP_W    = 31;
  localparam logic [RECIP_W-1:0] DUTY_RECIP =
    RECIP_W'(((64'd1 << DUTY_SHIFT) + DUTY_DEN - 64'd1) / DUTY_DEN);

  localparam logic [CLOCK_W-1:0] LOAD_MAX = '1;
  localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(1250000);
  localparam logic [ALOAD_W-1:0] ALOAD_RESET = ALOAD_W'(1249);

  // Multiplier operand B carries either a weight or a duty count
  localparam int MUL_B_W = (WEIGHT_FRAC_BITS > DUTY_W) ? WEIGHT_FRAC_BITS : DUTY_W;
  localparam int PROD_W  = FREQ_W + MUL_B_W;

  // Shared divider: dividend holds pwm_clock
  localparam int DIV_N     = CLOCK_W;
  localparam int DIV_CNT_W = $clog2(DIV_N);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_CLOCK   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_LOAD = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WEIGHT,
    S_FMUL,
    S_FREQ,
    S_DIV1,
    S_AMUL,
    S_ALOAD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic item_ready;
    logic div_step;
  } ctl_t;

  localparam int WPAIR_W = 2 * WEIGHT_FRAC_BITS;
  localparam logic [63:0] Q31_ONE = 64'd1 << 31;

  // Bit-serial unsigned divide, used only while the table is built
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Weights for distance m from the nearer ramp end: {past midpoint, up to midpoint}
  function automatic logic [WPAIR_W-1:0] weight_pair(input int m);
    logic [63:0] n;
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] wmax;
    logic [63:0] w_lo;
    logic [63:0] w_hi;
    n = 64'(5 * RAMP_STEPS - 10 * m);
    u = (n << 26) / RAMP_STEPS;
    term = Q31_ONE;
    pos = Q31_ONE;
    neg = '0;
    for (int k = 1; k <= 8; k++) begin
      term = div_u64((term * u) >> 31, 64'(k));
      if ((k & 1) != 0) neg = neg + term;
      else pos = pos + term;
    end
    e = (pos > neg) ? (pos - neg) : '0;
    if (e > Q31_ONE) e = Q31_ONE;
    for (int k = 0; k < 5; k++) begin
      e = (e * e + (64'd1 << 30)) >> 31;
    end
    den = Q31_ONE + e;
    wmax = (64'd1 << WEIGHT_FRAC_BITS) - 64'd1;
    w_lo = div_u64((e << WEIGHT_FRAC_BITS) + (den >> 1), den);
    w_hi = div_u64((Q31_ONE << WEIGHT_FRAC_BITS) + (den >> 1), den);
    if (w_lo > wmax) w_lo = wmax;
    if (w_hi > wmax) w_hi = wmax;
    return {w_hi[WEIGHT_FRAC_BITS-1:0], w_lo[WEIGHT_FRAC_BITS-1:0]};
  endfunction

  function automatic logic [W_ENTRIES*WPAIR_W-1:0] build_weights();
    logic [W_ENTRIES*WPAIR_W-1:0] t;
    t = '0;
    for (int m = 0; m < W_ENTRIES; m++) begin
      t[m*WPAIR_W +: WPAIR_W] = weight_pair(m);
    end
    return t;
  endfunction

  localparam logic [W_ENTRIES*WPAIR_W-1:0] W_TABLE = build_weights();

endpackage

### rtl/ssr_item_if.sv
// Input channel of the ramp unit: start and tick commands.
interface ssr_item_if import ssr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [FREQ_W-1:0] start_frequency;
  logic [FREQ_W-1:0] target_frequency;

  modport source(output valid, command, start_frequency, target_frequency, input ready);
  modport sink(input valid, command, start_frequency, target_frequency, output ready);
endinterface

### rtl/ssr_result_if.sv
// Output channel of the ramp unit: one ramp point per transaction.
interface ssr_result_if import ssr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] step_index;
  logic [FREQ_W-1:0]  step_frequency;
  logic [CLOCK_W-1:0] period_load;
  logic [PULSE_W-1:0] step_pulse_width;
  logic [ALOAD_W-1:0] analog_pulse_width;
  logic               divide_error;
  logic               last;

  modport source(output valid, step_index, step_frequency, period_load, step_pulse_width,
                 analog_pulse_width, divide_error, last, input ready);
  modport sink(input valid, step_index, step_frequency, period_load, step_pulse_width,
               analog_pulse_width, divide_error, last, output ready);
endinterface

### rtl/sigmoid_step_rate_ramp_unit.sv
// Sigmoid S-curve step-rate ramp generator with a shared multiplier and divider.
// A start transaction (command 0) latches start and target frequency and gives no
// result. Each tick (command 1) of an active ramp yields one point, 0 to RAMP_STEPS;
// the frequency follows start + (target - start) * w(s), with w(s) a Q0.16 sigmoid
// weight from a constant table folded about the ramp midpoint. A tick uses one 22-bit
// restoring divider that retires one quotient bit per cycle for pwm_clock / f, plus
// one shared 17-bit multiplier used twice and a reciprocal multiply that divides the
// scaled analog duty by 9000. The input is not ready while a tick is in work; a
// finished point waits in the output register while the next command is taken.
// Ticks outside a ramp are dropped, and a zero frequency flags divide_error with a
// saturated period load.
module sigmoid_step_rate_ramp_unit import ssr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CLOCK_W-1:0]   cfg_data,
  ssr_item_if.sink             item,
  ssr_result_if.source         result
);

  state_t state;
  state_t state_next;
  ctl_t   ctl;

  logic [CLOCK_W-1:0] pwm_clock;
  logic [ALOAD_W-1:0] analog_load;

  logic              ramp_active;
  logic [CNT_W-1:0]  counter;
  logic [FREQ_W-1:0] ramp_start;
  logic [FREQ_W-1:0] ramp_target;

  logic [WEIGHT_FRAC_BITS-1:0] w_reg;
  logic [PROD_W-1:0]           prod;
  logic [FREQ_W-1:0]           f_reg;
  logic [CLOCK_W-1:0]          load_reg;

  logic [FREQ_W-1:0]    rem;
  logic [DIV_N-1:0]     quo;
  logic [FREQ_W-1:0]    divisor;
  logic [DIV_CNT_W-1:0] cnt;

  logic                  accept;
  logic                  div_done;
  logic                  out_free;
  logic                  at_last;
  logic [CNT_W:0]        two_s;
  logic                  hi_side;
  logic [CNT_W-1:0]      m_full;
  logic [M_W-1:0]        m;
  logic [WPAIR_W-1:0]    w_entry;
  logic [WEIGHT_FRAC_BITS-1:0] w_sel;
  logic                  rising;
  logic [FREQ_W-1:0]     diff_abs;
  logic [FREQ_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     mul_out;
  logic [PROD_W:0]       up_sum;
  logic [FREQ_W-1:0]     f_calc;
  logic [FREQ_W-1:0]     f_minus;
  logic [DUTY_W-1:0]     duty;
  logic [FREQ_W:0]       shifted;
  logic                  sub_ok;
  logic [FREQ_W:0]       sub_val;
  logic [DIV_N-1:0]      quo_m1;
  logic [SCALE_W+RECIP_W-1:0] scaled;
  logic [ALOAD_W-1:0]    apw;
  logic [CNT_W+INDEX_W-1:0] idx_ext;

  assign accept   = item.valid && item.ready;
  assign div_done = (cnt == DIV_CNT_W'(DIV_N - 1));
  assign out_free = !result.valid || result.ready;
  assign at_last  = (counter == CNT_W'(RAMP_STEPS));
  assign idx_ext  = {{INDEX_W{1'b0}}, counter};

  // Fold the step index about the midpoint into the weight table
  assign two_s   = {counter, 1'b0};
  assign hi_side = two_s > (CNT_W + 1)'(RAMP_STEPS);
  assign m_full  = hi_side ? (CNT_W'(RAMP_STEPS) - counter) : counter;
  assign m       = m_full[M_W-1:0];
  assign w_entry = W_TABLE[m*WPAIR_W +: WPAIR_W];
  assign w_sel   = hi_side ? w_entry[WPAIR_W-1:WEIGHT_FRAC_BITS]
                           : w_entry[WEIGHT_FRAC_BITS-1:0];

  assign rising   = ramp_start < ramp_target;
  assign diff_abs = rising ? (ramp_target - ramp_start) : (ramp_start - ramp_target);

  // Falling ramp rounds the step up so the frequency truncates toward target
  assign up_sum = {1'b0, prod} + (PROD_W + 1)'((1 << WEIGHT_FRAC_BITS) - 1);
  assign f_calc = rising ? (ramp_start + prod[WEIGHT_FRAC_BITS +: FREQ_W])
                         : (ramp_start - up_sum[WEIGHT_FRAC_BITS +: FREQ_W]);

  assign f_minus = f_reg - F_LOW;
  assign duty    = (f_reg > F_LOW && f_reg < F_HIGH) ? f_minus[DUTY_W-1:0] : '0;

  // Shared multiplier
  assign mul_a   = (state == S_AMUL) ? {{(FREQ_W - ALOAD_W){1'b0}}, analog_load} : diff_abs;
  assign mul_b   = (state == S_AMUL) ? MUL_B_W'(duty) : MUL_B_W'(w_reg);
  assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Divide the scaled duty by 9000 through its reciprocal
  assign scaled = (SCALE_W + RECIP_W)'(prod[SCALE_W-1:0]) * (SCALE_W + RECIP_W)'(DUTY_RECIP);

  // Shared restoring divider step
  assign shifted = {rem, quo[DIV_N-1]};
  assign sub_ok  = shifted >= {1'b0, divisor};
  assign sub_val = shifted - {1'b0, divisor};

  assign quo_m1 = quo - DIV_N'(1);

  always_comb begin
    if (f_reg <= F_LOW) apw = '0;
    else if (f_reg >= F_HIGH) apw = analog_load;
    else apw = quo[ALOAD_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && item.command == CMD_TICK && ramp_active) state_next = S_WEIGHT;
      end
      S_WEIGHT: state_next = S_FMUL;
      S_FMUL:   state_next = S_FREQ;
      S_FREQ:   state_next = S_DIV1;
      S_DIV1: begin
        if (div_done) state_next = S_AMUL;
      end
      S_AMUL:   state_next = S_ALOAD;
      S_ALOAD:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.item_ready = (state == S_IDLE);
    ctl.div_step   = (state == S_DIV1);
  end

  assign item.ready = ctl.item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pwm_clock    <= CLOCK_RESET;
      analog_load  <= ALOAD_RESET;
      ramp_active  <= 1'b0;
      counter      <= '0;
      ramp_start   <= '0;
      ramp_target  <= '0;
      cnt          <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_index)
          CFG_PWM_CLOCK:   pwm_clock <= cfg_data;
          CFG_ANALOG_LOAD: analog_load <= cfg_data[ALOAD_W-1:0];
          default: ;
        endcase
      end

      if (result.valid && result.ready && state != S_DONE) result.valid <= 1'b0;

      if (ctl.div_step) begin
        rem <= sub_ok ? sub_val[FREQ_W-1:0] : shifted[FREQ_W-1:0];
        quo <= {quo[DIV_N-2:0], sub_ok};
        cnt <= cnt + DIV_CNT_W'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (accept && item.command == CMD_START) begin
            ramp_start  <= item.start_frequency;
            ramp_target <= item.target_frequency;
            counter     <= '0;
            ramp_active <= 1'b1;
          end
        end
        S_WEIGHT: w_reg <= w_sel;
        S_FMUL:   prod <= mul_out;
        S_FREQ: begin
          f_reg   <= f_calc;
          rem     <= '0;
          quo     <= DIV_N'(pwm_clock);
          divisor <= (f_calc == '0) ? FREQ_W'(1) : f_calc;
          cnt     <= '0;
        end
        S_DIV1: ;
        S_AMUL: begin
          // Period load is quotient minus one, floored at zero, saturated for a zero frequency
          if (f_reg == '0) load_reg <= LOAD_MAX;
          else if (quo == '0) load_reg <= '0;
          else load_reg <= quo_m1[CLOCK_W-1:0];
          prod <= mul_out;
        end
        S_ALOAD: begin
          // Hold the analog pulse width in the quotient register
          quo <= DIV_N'(scaled[DUTY_SHIFT +: ALOAD_W]);
        end
        S_DONE: begin
          if (out_free) begin
            result.valid              <= 1'b1;
            result.step_index         <= idx_ext[INDEX_W-1:0];
            result.step_frequency     <= f_reg;
            result.period_load        <= load_reg;
            result.step_pulse_width   <= load_reg[CLOCK_W-1:1];
            result.analog_pulse_width <= apw;
            result.divide_error       <= (f_reg == '0);
            result.last               <= at_last;
            if (at_last) begin
              ramp_active <= 1'b0;
              counter     <= '0;
            end else begin
              counter <= counter + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the completion state");

  a_zero_freq_saturates: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.divide_error |->
      result.period_load == LOAD_MAX && result.step_frequency == '0)
    else $error("divide error without saturated load");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.last |-> result.step_index == INDEX_W'(RAMP_STEPS))
    else $error("last point carries wrong index");

  a_idle_counter: assert property (@(posedge clk) disable iff (rst)
    !ramp_active |-> counter == '0)
    else $error("step counter nonzero outside a ramp");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    ctl.div_step |-> !item.ready)
    else $error("input ready while divider runs");

endmodule

### tb/tb_sigmoid_step_rate_ramp_unit.sv
// Self-checking testbench of the sigmoid step-rate ramp unit: directed corners, then random ramps.
module tb_sigmoid_step_rate_ramp_unit;
  import ssr_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [FREQ_W-1:0]  freq;
    logic [CLOCK_W-1:0] load;
    logic [PULSE_W-1:0] pulse;
    logic [ALOAD_W-1:0] apw;
    logic               err;
    logic               is_last;
  } ramp_point_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CLOCK_W-1:0] cfg_data;

  ssr_item_if   item_ch();
  ssr_result_if result_ch();

  sigmoid_step_rate_ramp_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  // Predicted ramp state and register copies
  logic               ramp_on;
  int unsigned        point_idx;
  logic [FREQ_W-1:0]  ramp_from;
  logic [FREQ_W-1:0]  ramp_to;
  logic [CLOCK_W-1:0] clock_hz;
  logic [ALOAD_W-1:0] aload;

  ramp_point_t expected_points[$];
  int errors;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_sigmoid_step_rate_ramp_unit: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sigmoid weight in Q0.16 for point s, from a Taylor series of exp(-|t|/32) squared five times
  function automatic logic [63:0] curve_weight(input int unsigned s);
    logic [63:0] one, span, half, n, u, term, pos, neg, e, num, den, w, wmax;
    logic first_half;
    one = 64'd1 << 31;
    wmax = (64'd1 << WEIGHT_FRAC_BITS) - 64'd1;
    span = 64'(10 * s);
    half = 64'(5 * RAMP_STEPS);
    first_half = (span <= half);
    n = first_half ? half - span : span - half;
    u = (n << 26) / 64'(RAMP_STEPS);
    term = one;
    pos = one;
    neg = '0;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * u) >> 31) / 64'(k);
      if (k % 2 == 1) neg += term;
      else pos += term;
    end
    e = (pos > neg) ? pos - neg : '0;
    if (e > one) e = one;
    repeat (5) e = (e * e + (64'd1 << 30)) >> 31;
    num = (first_half ? e : one) << WEIGHT_FRAC_BITS;
    den = one + e;
    w = (num + den / 2) / den;
    return (w > wmax) ? wmax : w;
  endfunction

  // Update the ramp state for one accepted transaction and queue the point it yields
  task automatic advance_ramp(input logic cmd, input logic [FREQ_W-1:0] sf,
                              input logic [FREQ_W-1:0] tf);
    logic [63:0] w, f, drop, load, apw;
    ramp_point_t pt;
    if (cmd == CMD_START) begin
      ramp_from = sf;
      ramp_to = tf;
      point_idx = 0;
      ramp_on = 1'b1;
    end else if (ramp_on) begin
      w = curve_weight(point_idx);
      if (ramp_from < ramp_to) begin
        f = 64'(ramp_from) + (((64'(ramp_to) - 64'(ramp_from)) * w) >> WEIGHT_FRAC_BITS);
      end else begin
        // Round the drop up so the result truncates toward the target
        drop = (64'(ramp_from) - 64'(ramp_to)) * w;
        f = 64'(ramp_from) - ((drop + (64'd1 << WEIGHT_FRAC_BITS) - 64'd1) >> WEIGHT_FRAC_BITS);
      end
      f = f & ((64'd1 << FREQ_W) - 64'd1);
      if (f == 0) begin
        load = 64'(LOAD_MAX);
      end else begin
        load = 64'(clock_hz) / f;
        if (load != 0) load = load - 64'd1;
      end
      if (f <= 64'd1000) apw = '0;
      else if (f >= 64'd10000) apw = 64'(aload);
      else apw = (64'(aload) * (f - 64'd1000)) / 64'd9000;
      pt.idx = INDEX_W'(point_idx);
      pt.freq = f[FREQ_W-1:0];
      pt.load = load[CLOCK_W-1:0];
      pt.pulse = load[PULSE_W:1];
      pt.apw = apw[ALOAD_W-1:0];
      pt.err = (f == 0);
      pt.is_last = (point_idx >= RAMP_STEPS);
      expected_points.push_back(pt);
      if (pt.is_last) begin
        ramp_on = 1'b0;
        point_idx = 0;
      end else begin
        point_idx++;
      end
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : point_check
    ramp_point_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected ramp point, expected none, actual index %0d freq %0d",
                 $time, result_ch.step_index, result_ch.step_frequency);
        errors++;
      end else begin
        want = expected_points.pop_front();
        check_field("step_index", want.idx, result_ch.step_index);
        check_field("step_frequency", want.freq, result_ch.step_frequency);
        check_field("period_load", want.load, result_ch.period_load);
        check_field("step_pulse_width", want.pulse, result_ch.step_pulse_width);
        check_field("analog_pulse_width", want.apw, result_ch.analog_pulse_width);
        check_field("divide_error", want.err, result_ch.divide_error);
        check_field("last", want.is_last, result_ch.last);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high after the transaction
  task automatic send_item(input logic cmd, input logic [FREQ_W-1:0] sf,
                           input logic [FREQ_W-1:0] tf);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.command <= cmd;
    item_ch.start_frequency <= sf;
    item_ch.target_frequency <= tf;
    do @(posedge clk); while (!item_ch.ready);
    advance_ramp(cmd, sf, tf);
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_points.size() != 0);
  endtask

  // Wait until every expected point is taken, then keep the input idle for a settling pause
  task automatic settle();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CLOCK_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_PWM_CLOCK:   clock_hz = value;
      CFG_ANALOG_LOAD: aload = value[ALOAD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [FREQ_W-1:0] pick_frequency();
    case ($urandom_range(3))
      0: return FREQ_W'($urandom);
      1: return FREQ_W'($urandom_range(2000));
      2: return FREQ_W'($urandom_range(12000, 800));
      default: return FREQ_W'($urandom_range(131071, 100000));
    endcase
  endfunction

  task automatic test_ticks_without_ramp();
    send_item(CMD_TICK, '1, '1);
    send_item(CMD_TICK, '0, '0);
  endtask

  task automatic test_zero_frequency();
    send_item(CMD_START, '0, '0);
    send_item(CMD_TICK, '0, '0);
  endtask

  task automatic test_full_scale_ramps();
    send_item(CMD_START, '1, '0);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_START, '0, '1);
    send_item(CMD_TICK, '0, '0);
  endtask

  // A start in the middle of a ramp goes back to point 0
  task automatic test_restart();
    send_item(CMD_START, FREQ_W'(5000), FREQ_W'(20000));
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_START, FREQ_W'(3000), FREQ_W'(1000));
    send_item(CMD_TICK, '0, '0);
  endtask

  // Equal start and target pins the frequency at the edges of the duty window
  task automatic test_analog_band();
    send_item(CMD_START, FREQ_W'(1000), FREQ_W'(1000));
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_START, FREQ_W'(1001), FREQ_W'(1001));
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_START, FREQ_W'(10000), FREQ_W'(10000));
    send_item(CMD_TICK, '0, '0);
  endtask

  task automatic test_register_extremes();
    settle();
    write_register(CFG_PWM_CLOCK, '0);
    write_register(CFG_ANALOG_LOAD, '0);
    send_item(CMD_START, FREQ_W'(1), '1);
    send_item(CMD_TICK, '0, '0);
    settle();
    // Frequency above the PWM clock: the load clamps at zero
    write_register(CFG_PWM_CLOCK, CLOCK_W'(1));
    write_register(CFG_ANALOG_LOAD, CLOCK_W'(65535));
    send_item(CMD_START, FREQ_W'(12000), FREQ_W'(12000));
    send_item(CMD_TICK, '0, '0);
    settle();
    write_register(CFG_PWM_CLOCK, '1);
    write_register(CFG_ANALOG_LOAD, CLOCK_W'(1));
    send_item(CMD_START, FREQ_W'(1), FREQ_W'(1));
    send_item(CMD_TICK, '0, '0);
  endtask

  // Mostly long ramps with random end points; rare restarts and stray ticks
  task automatic drive_ramp_traffic(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if (!ramp_on && $urandom_range(9) == 0) begin
        send_item(CMD_TICK, FREQ_W'($urandom), FREQ_W'($urandom));
      end else if (!ramp_on || $urandom_range(999) == 0) begin
        send_item(CMD_START, pick_frequency(), pick_frequency());
        sent++;
      end else begin
        send_item(CMD_TICK, FREQ_W'($urandom), FREQ_W'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random_ramps();
    settle();
    write_register(CFG_PWM_CLOCK, CLOCK_W'(4000000));
    write_register(CFG_ANALOG_LOAD, CLOCK_W'(65535));
    drive_ramp_traffic(300);
    settle();
    write_register(CFG_PWM_CLOCK, CLOCK_W'($urandom_range(4000000, 1)));
    write_register(CFG_ANALOG_LOAD, CLOCK_W'($urandom_range(65535, 1)));
    send_idle_pct = 45;
    recv_idle_pct = 13;
    drive_ramp_traffic(150);
    pause_until_drained();
    drive_ramp_traffic(150);
    settle();
    write_register(CFG_PWM_CLOCK, CLOCK_W'(1250000));
    write_register(CFG_ANALOG_LOAD, CLOCK_W'(1249));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drive_ramp_traffic(300);
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    send_idle_pct = 13;
    recv_idle_pct = 45;
    ramp_on = 1'b0;
    point_idx = 0;
    ramp_from = '0;
    ramp_to = '0;
    clock_hz = CLOCK_RESET;
    aload = ALOAD_RESET;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_PWM_CLOCK;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.command = CMD_START;
    item_ch.start_frequency = '0;
    item_ch.target_frequency = '0;
    result_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_ticks_without_ramp();
    test_zero_frequency();
    test_full_scale_ramps();
    test_restart();
    test_analog_band();
    test_register_extremes();
    test_random_ramps();

    settle();
    if (errors == 0) begin
      $display("tb_sigmoid_step_rate_ramp_unit: PASS");
    end else begin
      $display("tb_sigmoid_step_rate_ramp_unit: FAIL");
    end
    $finish;
  end

endmodule
